// ----- hdl/htbd_pkg.sv -----
// Shared codes and controller/datapath interface types for the Huffman tree bit decoder.
// No dependencies; imported by htbd_ctrl, htbd_datapath and the top level.
package htbd_pkg;

    // input word function codes
    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_LOAD    = 2'd1;
    localparam logic [1:0] FUNC_DECODE  = 2'd2;
    localparam logic [1:0] FUNC_RESTART = 2'd3;

    // result word status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // node memory read address select
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_NONE = 2'd0;
    localparam rd_sel_t RD_POS  = 2'd1;
    localparam rd_sel_t RD_ROOT = 2'd2;
    localparam rd_sel_t RD_CHILD = 2'd3;

    typedef struct packed {
        logic       latch;        // capture input word, reset walk index
        rd_sel_t    rd_sel;
        logic       dec_mode;     // child chosen by coded bit instead of path bit
        logic       take_child;   // advance walk to the selected child
        logic       walk_break;   // hold the node read at the end of the existing path
        logic       create_root;
        logic       alloc;        // link a new node and make it current
        logic       final_write;
        logic       load_zero;
        logic       clear_tree;
        logic       pos_root;
        logic       dec_advance;
        logic       emit;
        logic [1:0] emit_status;
    } htbd_cmd_t;

    typedef struct packed {
        logic present;
        logic len_in_zero;
        logic walk_done;
        logic last_step;
        logic no_room;
        logic child_zero;
        logic leaf;
        logic out_free;
    } htbd_stat_t;

endpackage

// ----- hdl/htbd_ctrl.sv -----
// Sequencing state machine for load walks, node allocation and decode steps.
// Depends on htbd_pkg; drives htbd_datapath through htbd_cmd_t.
module htbd_ctrl
    import htbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_func,
    output logic       s_ready,
    input  htbd_stat_t stat,
    output htbd_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_ALLOC  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_DCHILD = 3'd5;
    localparam logic [2:0] S_DLEAF  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_func)
                        FUNC_CLEAR: begin
                            cmd.clear_tree = 1'b1;
                        end
                        FUNC_LOAD: begin
                            cmd.latch = 1'b1;
                            if (stat.len_in_zero) begin
                                cmd.load_zero = 1'b1;
                            end else if (stat.present) begin
                                cmd.rd_sel = RD_ROOT;
                                state_next = S_WALK;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        FUNC_DECODE: begin
                            cmd.latch  = 1'b1;
                            cmd.rd_sel = RD_POS;
                            state_next = S_DCHILD;
                        end
                        FUNC_RESTART: begin
                            cmd.pos_root = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = S_IDLE;
                end else if (stat.child_zero) begin
                    cmd.walk_break = 1'b1;
                    state_next     = S_CHECK;
                end else begin
                    cmd.rd_sel     = RD_CHILD;
                    cmd.take_child = 1'b1;
                end
            end
            S_CHECK: begin
                if (stat.no_room) begin
                    // hold until the result register can take the word
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_FULL;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.create_root = !stat.present;
                    state_next      = S_ALLOC;
                end
            end
            S_ALLOC: begin
                cmd.alloc = 1'b1;
                if (stat.last_step) begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL: begin
                cmd.final_write = 1'b1;
                state_next      = S_IDLE;
            end
            S_DCHILD: begin
                cmd.dec_mode = 1'b1;
                if (!stat.present || stat.child_zero) begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_MISS;
                        cmd.pos_root    = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.rd_sel     = RD_CHILD;
                    cmd.take_child = 1'b1;
                    state_next     = S_DLEAF;
                end
            end
            S_DLEAF: begin
                if (stat.leaf) begin
                    if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.pos_root    = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else begin
                    cmd.dec_advance = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/htbd_datapath.sv -----
// Node memory, walk registers, tree bookkeeping and the result register.
// Depends on htbd_pkg; commanded by htbd_ctrl.
module htbd_datapath
    import htbd_pkg::*;
#(
    parameter int NODE_COUNT   = 512,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_code_bits,
    input  logic [4:0]  s_code_len,
    input  logic [7:0]  s_symbol_in,
    input  logic        s_coded_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol_out,
    output logic [1:0]  m_status,
    input  htbd_cmd_t   cmd,
    output htbd_stat_t  stat
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int NW = ((CW > LW) ? CW : LW) + 1;

    typedef struct packed {
        logic [IW-1:0] left;
        logic [IW-1:0] right;
        logic [7:0]    sym;
    } entry_t;

    entry_t        mem [NODE_COUNT];
    entry_t        rdata_reg;
    entry_t        cur_entry_reg;
    entry_t        cur_entry_next;
    entry_t        wr_data;
    entry_t        alloc_entry;
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic [IW-1:0] wr_addr;
    logic          wr_en;

    logic [15:0]   bits_reg;
    logic [LW-1:0] len_reg;
    logic [7:0]    sym_reg;
    logic          bit_reg;
    logic [LW-1:0] step_reg;
    logic [LW-1:0] step_next;
    logic [IW-1:0] cur_idx_reg;
    logic [IW-1:0] cur_idx_next;

    logic          present_reg;
    logic          present_next;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] used_next;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] pos_next;

    logic          m_valid_reg;
    logic [7:0]    m_symbol_reg;
    logic [1:0]    m_status_reg;

    logic [LW-1:0] len_in;
    logic [5:0]    path_pos;
    logic          path_bit;
    logic          child_bit;
    logic [IW-1:0] child;
    logic [IW-1:0] new_idx;
    logic [NW-1:0] need;
    logic [NW-1:0] room;

    // saturate the requested length to the longest supported code
    assign len_in = ({1'b0, s_code_len} > 6'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                            : LW'(s_code_len);

    // step i uses bit (len-1-i); bits above the code word read as zero
    assign path_pos  = 6'(len_reg) - 6'(step_reg) - 6'd1;
    assign path_bit  = (path_pos < 6'd16) && bits_reg[path_pos[3:0]];
    assign child_bit = cmd.dec_mode ? bit_reg : path_bit;
    assign child     = child_bit ? rdata_reg.right : rdata_reg.left;
    assign new_idx   = used_reg[IW-1:0];

    assign need = NW'(len_reg) - NW'(step_reg) + NW'(!present_reg);
    assign room = NW'(NODE_COUNT) - NW'(used_reg);

    assign stat.present     = present_reg;
    assign stat.len_in_zero = (len_in == '0);
    assign stat.walk_done   = (step_reg == len_reg);
    assign stat.last_step   = ((step_reg + LW'(1)) == len_reg);
    assign stat.no_room     = (need > room);
    assign stat.child_zero  = (child == '0);
    assign stat.leaf        = (rdata_reg.left == '0) && (rdata_reg.right == '0);
    assign stat.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        rd_en = (cmd.rd_sel != RD_NONE);
        case (cmd.rd_sel)
            RD_POS:   rd_addr = pos_reg;
            RD_CHILD: rd_addr = child;
            default:  rd_addr = '0;
        endcase
    end

    always_comb begin
        alloc_entry = cur_entry_reg;
        if (path_bit) begin
            alloc_entry.right = new_idx;
        end else begin
            alloc_entry.left = new_idx;
        end
    end

    always_comb begin
        wr_en   = cmd.load_zero || cmd.alloc || cmd.final_write;
        wr_addr = cur_idx_reg;
        wr_data = cur_entry_reg;
        if (cmd.load_zero) begin
            wr_addr = '0;
            wr_data = '{left: '0, right: '0, sym: s_symbol_in};
        end else if (cmd.alloc) begin
            wr_data = alloc_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        step_next      = step_reg;
        cur_idx_next   = cur_idx_reg;
        cur_entry_next = cur_entry_reg;
        if (cmd.latch) begin
            step_next    = '0;
            cur_idx_next = '0;
        end else if (cmd.take_child) begin
            step_next    = step_reg + LW'(1);
            cur_idx_next = child;
        end else if (cmd.walk_break) begin
            cur_entry_next = rdata_reg;
        end else if (cmd.create_root) begin
            cur_idx_next   = '0;
            cur_entry_next = '0;
        end else if (cmd.alloc) begin
            step_next      = step_reg + LW'(1);
            cur_idx_next   = new_idx;
            cur_entry_next = '{left: '0, right: '0,
                               sym: stat.last_step ? sym_reg : 8'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            bits_reg <= s_code_bits;
            len_reg  <= len_in;
            sym_reg  <= s_symbol_in;
            bit_reg  <= s_coded_bit;
        end
        step_reg      <= step_next;
        cur_idx_reg   <= cur_idx_next;
        cur_entry_reg <= cur_entry_next;
    end

    always_comb begin
        present_next = present_reg;
        used_next    = used_reg;
        pos_next     = pos_reg;
        if (cmd.clear_tree) begin
            present_next = 1'b0;
            used_next    = '0;
            pos_next     = '0;
        end else if (cmd.load_zero) begin
            present_next = 1'b1;
            used_next    = CW'(1);
            pos_next     = '0;
        end else if (cmd.create_root) begin
            present_next = 1'b1;
            used_next    = CW'(1);
        end else if (cmd.alloc) begin
            used_next = used_reg + CW'(1);
        end
        if (cmd.pos_root) begin
            pos_next = '0;
        end else if (cmd.dec_advance) begin
            pos_next = cur_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            used_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            present_reg <= present_next;
            used_reg    <= used_next;
            pos_reg     <= pos_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= cmd.emit_status;
            m_symbol_reg <= (cmd.emit_status == ST_OK) ? rdata_reg.sym : 8'd0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_symbol_out = m_symbol_reg;
    assign m_status     = m_status_reg;

endmodule

// ----- hdl/huffman_tree_bit_decoder.sv -----
// Huffman code tree decoder: top level joining htbd_ctrl and htbd_datapath.
// Depends on htbd_pkg.
//
// Input channel (s_*): one word per operation, selected by s_func: clear the tree,
// load one code (s_code_bits read MSB first over s_code_len steps, leaf gets
// s_symbol_in), decode one coded bit, or restart decoding at the root.
// Result channel (m_*): at most one word per input word. A decode that reaches a
// leaf returns its symbol with status 0; a step into a missing branch returns
// status 1; a load that does not fit in the node store returns status 2.
// Sequence: clear, restart and zero-length load finish in the idle state that accepts
// them. A decode bit makes two dependent node memory reads (current node, then
// child), or only the first on a missing branch; the result word is registered
// once the result register is free. A load over a present tree walks the d
// existing nodes at one memory read each, finds the missing branch, checks room,
// links m new nodes one per cycle through the single write port, then writes the
// last node. A load into an empty tree skips the walk; one whose whole path exists
// ends after the walk.
// Reset: tree empty, no nodes used, decode at the root; no memory clearing pass.
// Stall: a finished result waits in the output register; the next word is still
// accepted and only stalls at the point where it must deliver its own result.
module huffman_tree_bit_decoder
    import htbd_pkg::*;
#(
    parameter int NODE_COUNT   = 512,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_code_bits,
    input  logic [4:0]  s_code_len,
    input  logic [7:0]  s_symbol_in,
    input  logic        s_coded_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol_out,
    output logic [1:0]  m_status
);

    htbd_cmd_t  cmd;
    htbd_stat_t stat;

    htbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    htbd_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_code_bits  (s_code_bits),
        .s_code_len   (s_code_len),
        .s_symbol_in  (s_symbol_in),
        .s_coded_bit  (s_coded_bit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_symbol_out (m_symbol_out),
        .m_status     (m_status),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ----- tb/huffman_tree_bit_decoder_test.sv -----
// Self-checking testbench for huffman_tree_bit_decoder: directed tree builds, then random
// prefix-code sessions and store-filling runs, with random stalls on both channels.
// Depends on htbd_pkg and the huffman_tree_bit_decoder RTL.
module huffman_tree_bit_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import htbd_pkg::*;

    localparam int TREE_NODES   = 512;
    localparam int CODE_LEN_MAX = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int TRAIL_CYCLES = 60;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] code_bits;
        logic [4:0]  code_len;
        logic [7:0]  symbol;
        logic        coded_bit;
    } tree_op_t;

    typedef struct {
        logic [7:0] symbol;
        logic [1:0] status;
    } result_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_CLEAR;
    logic [15:0] s_code_bits = '0;
    logic [4:0]  s_code_len = '0;
    logic [7:0]  s_symbol_in = '0;
    logic        s_coded_bit = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_symbol_out;
    logic [1:0]  m_status;

    // tree as the block should hold it
    bit           tree_built;
    bit [9:0]     left_child  [TREE_NODES];
    bit [9:0]     right_child [TREE_NODES];
    bit [7:0]     leaf_symbol [TREE_NODES];
    int           nodes_taken;
    int           walk_node;
    result_word_t awaited_words[$];

    tree_op_t queued_ops[$];
    tree_op_t live_op;
    bit       in_taken;
    int       send_wait, send_calm, take_wait, take_calm;
    int       mismatches;

    huffman_tree_bit_decoder #(
        .NODE_COUNT   (TREE_NODES),
        .MAX_CODE_LEN (CODE_LEN_MAX)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_code_bits  (s_code_bits),
        .s_code_len   (s_code_len),
        .s_symbol_in  (s_symbol_in),
        .s_coded_bit  (s_coded_bit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_symbol_out (m_symbol_out),
        .m_status     (m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic expect_word(input logic [7:0] sym, input logic [1:0] st);
        result_word_t w;
        w.symbol = sym;
        w.status = st;
        awaited_words.insert(awaited_words.size(), w);
    endtask

    task automatic step_tree(input tree_op_t op);
        int len, depth, cur, nxt, need;
        bit b;
        case (op.func)
            FUNC_CLEAR: begin
                tree_built = 1'b0;
                nodes_taken = 0;
                walk_node = 0;
            end
            FUNC_RESTART: walk_node = 0;
            FUNC_DECODE: begin
                nxt = 0;
                if (tree_built)
                    nxt = op.coded_bit ? int'(right_child[walk_node])
                                       : int'(left_child[walk_node]);
                if (nxt == 0) begin
                    expect_word(8'd0, ST_MISS);
                    walk_node = 0;
                end else if (left_child[nxt] == 0 && right_child[nxt] == 0) begin
                    expect_word(leaf_symbol[nxt], ST_OK);
                    walk_node = 0;
                end else begin
                    walk_node = nxt;
                end
            end
            default: begin
                len = (op.code_len > CODE_LEN_MAX) ? CODE_LEN_MAX : int'(op.code_len);
                if (len == 0) begin
                    left_child[0] = '0;
                    right_child[0] = '0;
                    leaf_symbol[0] = op.symbol;
                    nodes_taken = 1;
                    tree_built = 1'b1;
                    walk_node = 0;
                    return;
                end
                cur = 0;
                depth = 0;
                nxt = 1;
                // follow the part of the path that already exists
                while (tree_built && depth < len && nxt != 0) begin
                    b = op.code_bits[len - 1 - depth];
                    nxt = b ? int'(right_child[cur]) : int'(left_child[cur]);
                    if (nxt != 0) begin
                        cur = nxt;
                        depth++;
                    end
                end
                need = len - depth + (tree_built ? 0 : 1);
                if (need > TREE_NODES - nodes_taken) begin
                    expect_word(8'd0, ST_FULL);
                    return;
                end
                if (!tree_built) begin
                    left_child[0] = '0;
                    right_child[0] = '0;
                    leaf_symbol[0] = '0;
                    nodes_taken = 1;
                    tree_built = 1'b1;
                    cur = 0;
                end
                while (depth < len) begin
                    b = op.code_bits[len - 1 - depth];
                    left_child[nodes_taken] = '0;
                    right_child[nodes_taken] = '0;
                    leaf_symbol[nodes_taken] = (depth == len - 1) ? op.symbol : 8'd0;
                    if (b)
                        right_child[cur] = 10'(nodes_taken);
                    else
                        left_child[cur] = 10'(nodes_taken);
                    cur = nodes_taken;
                    nodes_taken++;
                    depth++;
                end
            end
        endcase
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_op(input tree_op_t op);
        queued_ops.insert(queued_ops.size(), op);
    endtask

    task automatic add_load(input logic [15:0] bits, input logic [4:0] len,
                            input logic [7:0] sym);
        queue_op('{FUNC_LOAD, bits, len, sym, 1'($urandom)});
    endtask

    task automatic add_decode(input logic bit_in);
        queue_op('{FUNC_DECODE, 16'($urandom), 5'($urandom), 8'($urandom), bit_in});
    endtask

    task automatic add_ctl(input logic [1:0] func);
        queue_op('{func, 16'($urandom), 5'($urandom), 8'($urandom), 1'($urandom)});
    endtask

    // input side: hold a word until taken, then idle for a random gap
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (send_wait > 0) begin
                s_valid <= 1'b0;
                send_wait--;
            end else if (queued_ops.size() != 0) begin
                live_op = queued_ops.pop_front();
                s_func <= live_op.func;
                s_code_bits <= live_op.code_bits;
                s_code_len <= live_op.code_len;
                s_symbol_in <= live_op.symbol;
                s_coded_bit <= live_op.coded_bit;
                s_valid <= 1'b1;
                if (send_calm > 0) begin
                    send_calm--;
                    send_wait = 0;
                end else begin
                    send_wait = pick_pause();
                    if ($urandom_range(0, 39) == 0)
                        send_calm = $urandom_range(20, 80);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random back-pressure with calm stretches
    always @(negedge aclk) begin
        if (take_wait > 0) begin
            m_ready <= 1'b0;
            take_wait--;
        end else begin
            m_ready <= 1'b1;
            if (take_calm > 0) begin
                take_calm--;
            end else begin
                take_wait = pick_pause();
                if ($urandom_range(0, 39) == 0)
                    take_calm = $urandom_range(20, 80);
            end
        end
    end

    always @(posedge aclk) begin
        result_word_t want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                step_tree(live_op);
            end
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: symbol %02h status %0d",
                                              m_symbol_out, m_status));
                end else begin
                    want = awaited_words.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_symbol_out !== want.symbol)
                        report_mismatch($sformatf("symbol %02h, expected %02h",
                                                  m_symbol_out, want.symbol));
                end
            end
        end
    end

    initial begin
        int k, lvl, leaves, session, directed_ops;
        logic [15:0] grown;
        logic [15:0] set_bits[$];
        int set_len[$];

        add_decode(1'b0);                   // empty tree
        add_ctl(FUNC_RESTART);
        add_load(16'hFFFF, 5'd0, 8'hA5);    // whole tree is one leaf
        add_decode(1'b1);
        add_load(16'h0000, 5'd1, 8'h11);    // root leaf grows a child
        add_load(16'h0001, 5'd1, 8'h22);
        add_load(16'hFFFE, 5'd1, 8'h33);    // final node exists, keeps 11
        add_decode(1'b0);
        add_decode(1'b1);
        add_ctl(FUNC_CLEAR);
        add_decode(1'b1);
        add_load(16'h0005, 5'd3, 8'hFF);    // root made on an empty tree
        add_load(16'hFFFF, 5'd31, 8'h00);   // length clips to 16
        add_load(16'h0000, 5'd16, 8'h5A);
        add_decode(1'b1);
        add_decode(1'b0);
        add_decode(1'b1);
        add_decode(1'b1);
        add_ctl(FUNC_RESTART);              // drop a half-walked code
        add_decode(1'b1);
        add_decode(1'b1);
        add_decode(1'b0);                   // no left child below
        add_load(16'h0002, 5'd2, 8'h77);    // path is all there already

        directed_ops = queued_ops.size();
        session = 0;
        while (queued_ops.size() - directed_ops < RANDOM_ITEMS) begin
            if (session == 2 || $urandom_range(0, 99) < 12) begin
                // long codes until the node store runs out
                add_ctl(FUNC_CLEAR);
                repeat ($urandom_range(40, 48)) begin
                    add_load(16'($urandom),
                             5'(($urandom_range(0, 3) == 0) ? $urandom_range(17, 31) : 16),
                             8'($urandom));
                    if ($urandom_range(0, 4) == 0)
                        add_decode(1'($urandom));
                end
                repeat ($urandom_range(10, 20))
                    add_decode(1'($urandom));
            end else begin
                if ($urandom_range(0, 1))
                    add_ctl(FUNC_CLEAR);
                else
                    add_load(16'($urandom), 5'd0, 8'($urandom));
                // grow a complete prefix code by splitting leaves
                leaves = $urandom_range(2, 12);
                set_bits.delete();
                set_len.delete();
                set_bits.insert(set_bits.size(), 16'd0);
                set_len.insert(set_len.size(), 0);
                while (set_len.size() < leaves) begin
                    k = $urandom_range(0, 1) ? set_len.size() - 1
                                             : $urandom_range(0, set_len.size() - 1);
                    grown = set_bits[k] << 1;
                    set_bits[k] = grown;
                    set_len[k] = set_len[k] + 1;
                    set_bits.insert(set_bits.size(), grown | 16'd1);
                    set_len.insert(set_len.size(), set_len[k]);
                end
                for (k = 0; k < leaves; k++)
                    add_load(set_bits[k] | (16'($urandom) << set_len[k]), 5'(set_len[k]),
                             8'($urandom));
                repeat ($urandom_range(8, 16)) begin
                    k = $urandom_range(0, leaves - 1);
                    case ($urandom_range(0, 29))
                        0: add_ctl(FUNC_RESTART);
                        1: add_decode(1'($urandom));
                        2: add_load(16'($urandom), 5'($urandom_range(0, 31)), 8'($urandom));
                        3: add_ctl(FUNC_CLEAR);
                        default: ;
                    endcase
                    for (lvl = set_len[k] - 1; lvl >= 0; lvl--) begin
                        if ($urandom_range(0, 49) == 0)
                            add_ctl(FUNC_RESTART);
                        add_decode(set_bits[k][lvl]);
                    end
                end
            end
            session++;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (queued_ops.size() != 0 || s_valid)
            @(posedge aclk);
        while (awaited_words.size() != 0)
            @(posedge aclk);
        repeat (TRAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS huffman_tree_bit_decoder");
        else
            $display("FAIL huffman_tree_bit_decoder");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d words still expected", awaited_words.size());
        $display("FAIL huffman_tree_bit_decoder");
        $finish;
    end

endmodule
